[design/swms_pkg.sv]
`default_nettype none

package swms_pkg;

  localparam int WINDOW_DEF = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Drive modes
  localparam logic [1:0] MODE_ECO   = 2'd0;
  localparam logic [1:0] MODE_SPORT = 2'd1;
  localparam logic [1:0] MODE_ROAD  = 2'd2;

  // Button kinds
  localparam logic [1:0] BTN_PHYSICAL = 2'd0;
  localparam logic [1:0] BTN_EXTERNAL = 2'd1;
  localparam logic [1:0] BTN_FIXED    = 2'd2;

  // Kill switch sources
  localparam logic [1:0] KILL_NONE         = 2'd0;
  localparam logic [1:0] KILL_BUTTON       = 2'd1;
  localparam logic [1:0] KILL_BUTTON_BRAKE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_SOURCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRASH_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAND_ENABLE = 2'd3;

  typedef struct packed {
    logic       button_pin;
    logic       crash_pin;
    logic       stand_pin;
    logic       set_external;
    logic [1:0] external_value;
    logic       reapply_request;
  } sample_t;

  typedef struct packed {
    logic       window_done;
    logic [1:0] drive_mode;
    logic       apply_mode;
    logic       warning_any;
    logic       warn_crash;
    logic       warn_stand;
    logic       warn_kill;
  } result_t;

  typedef struct packed {
    logic [1:0] button_kind;
    logic [1:0] kill_source;
    logic       crash_enable;
    logic       stand_enable;
  } cfg_t;

endpackage

`default_nettype wire

[design/swms_stream_if.sv]
`default_nettype none

interface swms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/swms_cfg_if.sv]
`default_nettype none

interface swms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swms_pkg::CFG_IDX_W-1:0]  index;
  logic [swms_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[design/swms_cfg_regs.sv]
`default_nettype none

module swms_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [swms_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [swms_pkg::CFG_DATA_W-1:0] wr_data,
  output swms_pkg::cfg_t                       cfg
);

  swms_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (wr_index)
        swms_pkg::REG_BUTTON_KIND:  regs.button_kind  <= wr_data;
        swms_pkg::REG_KILL_SOURCE:  regs.kill_source  <= wr_data;
        swms_pkg::REG_CRASH_ENABLE: regs.crash_enable <= wr_data[0];
        swms_pkg::REG_STAND_ENABLE: regs.stand_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[design/swms_window.sv]
`default_nettype none

module swms_window #(
  parameter int WINDOW = swms_pkg::WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire swms_pkg::sample_t smp,
  input  wire swms_pkg::cfg_t    cfg,
  output swms_pkg::result_t      res
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PROD_W = CNT_W + 3;
  localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
  localparam logic [PROD_W-1:0] HIGH_LIM = PROD_W'(4 * WINDOW);
  localparam logic [PROD_W-1:0] LOW_LIM  = PROD_W'(WINDOW);

  logic [CNT_W-1:0] tick_count, tick_count_next;
  logic [CNT_W-1:0] button_sum, button_sum_next;
  logic [CNT_W-1:0] crash_sum, crash_sum_next;
  logic [CNT_W-1:0] stand_sum, stand_sum_next;
  logic [1:0]       current_mode, current_mode_next;
  logic [1:0]       external_mode, external_mode_next;
  logic             kill_latched, kill_latched_next;
  logic             reapply_pending, reapply_pending_next;

  logic [CNT_W-1:0] tick_inc, button_acc, crash_acc, stand_acc;
  logic [1:0]       ext_eff, mode_now;
  logic             reap_eff, done, change, b_high, b_low, c_high, s_high;

  // sum * 5 as shift and add
  function automatic logic [PROD_W-1:0] times5(input logic [CNT_W-1:0] v);
    logic [PROD_W-1:0] w;
    w = PROD_W'(v);
    return (w << 2) + w;
  endfunction

  always_comb begin
    ext_eff  = (smp.set_external && smp.external_value <= swms_pkg::MODE_ROAD)
             ? smp.external_value : external_mode;
    reap_eff = reapply_pending | smp.reapply_request;

    tick_inc   = tick_count + CNT_W'(1);
    button_acc = button_sum + CNT_W'(smp.button_pin);
    crash_acc  = crash_sum + CNT_W'(smp.crash_pin);
    stand_acc  = stand_sum + CNT_W'(smp.stand_pin);
    done       = (tick_inc == WIN_CNT);

    b_high = times5(button_acc) > HIGH_LIM;
    b_low  = times5(button_acc) < LOW_LIM;
    c_high = times5(crash_acc) > HIGH_LIM;
    s_high = times5(stand_acc) > HIGH_LIM;

    kill_latched_next = kill_latched;
    if (done && cfg.button_kind == swms_pkg::BTN_PHYSICAL && b_low &&
        (cfg.kill_source == swms_pkg::KILL_BUTTON ||
         cfg.kill_source == swms_pkg::KILL_BUTTON_BRAKE)) begin
      kill_latched_next = 1'b1;
    end

    case (cfg.button_kind)
      swms_pkg::BTN_PHYSICAL: begin
        mode_now = current_mode;
        if (b_high) mode_now = swms_pkg::MODE_SPORT;
        if (b_low)  mode_now = swms_pkg::MODE_ECO;
        if (ext_eff == swms_pkg::MODE_ROAD) mode_now = swms_pkg::MODE_ROAD;
      end
      swms_pkg::BTN_EXTERNAL: mode_now = ext_eff;
      default:                mode_now = swms_pkg::MODE_SPORT;
    endcase

    change = done && ((current_mode != mode_now) ||
                      (current_mode != swms_pkg::MODE_SPORT && reap_eff));

    current_mode_next    = change ? mode_now : current_mode;
    external_mode_next   = (change && ext_eff != swms_pkg::MODE_ROAD) ? mode_now : ext_eff;
    reapply_pending_next = done ? 1'b0 : reap_eff;

    // close the window: clear counters
    tick_count_next = done ? '0 : tick_inc;
    button_sum_next = done ? '0 : button_acc;
    crash_sum_next  = done ? '0 : crash_acc;
    stand_sum_next  = done ? '0 : stand_acc;

    res.window_done = done;
    res.drive_mode  = current_mode_next;
    res.apply_mode  = change && !kill_latched_next;
    res.warn_crash  = done && cfg.crash_enable && c_high;
    res.warn_stand  = done && cfg.stand_enable && s_high;
    res.warn_kill   = done && kill_latched_next;
    res.warning_any = res.warn_crash | res.warn_stand | res.warn_kill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      button_sum      <= '0;
      crash_sum       <= '0;
      stand_sum       <= '0;
      current_mode    <= swms_pkg::MODE_SPORT;
      external_mode   <= swms_pkg::MODE_SPORT;
      kill_latched    <= 1'b0;
      reapply_pending <= 1'b1;
    end else if (step) begin
      tick_count      <= tick_count_next;
      button_sum      <= button_sum_next;
      crash_sum       <= crash_sum_next;
      stand_sum       <= stand_sum_next;
      current_mode    <= current_mode_next;
      external_mode   <= external_mode_next;
      kill_latched    <= kill_latched_next;
      reapply_pending <= reapply_pending_next;
    end
  end

  a_tick_in_window: assert property (@(posedge clk) disable iff (rst)
    tick_count < WIN_CNT)
    else $error("tick count left the window");

  a_kill_sticks: assert property (@(posedge clk) disable iff (rst)
    kill_latched |=> kill_latched)
    else $error("kill latch released without reset");

  a_apply_on_decision: assert property (@(posedge clk) disable iff (rst)
    (step && res.apply_mode) |-> (res.window_done && !kill_latched_next))
    else $error("apply raised outside a decision or while killed");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (step && !done) |=> (tick_count == $past(tick_count) + CNT_W'(1)))
    else $error("tick count failed to advance");

  a_window_clears: assert property (@(posedge clk) disable iff (rst)
    (step && done) |=> (tick_count == '0 && button_sum == '0 && !reapply_pending))
    else $error("window state not cleared after decision");

endmodule

`default_nettype wire

[design/sensor_window_mode_selector.sv]
// Channel   Dir   Payload
// --------  ----  ---------------------------------------------------------
// sample    sink  button/crash/stand pins, set_external, external_value,
//                 reapply_request (one tick per beat)
// result    src   window_done, drive_mode, apply_mode, warning flags
// cfg       sink  register index + write data, always ready
//
// One beat in, one beat out. A beat is captured in the input register,
// then the window logic updates its state and loads the result register;
// a new beat is taken every cycle while the result is not stalled.
// Synchronous active-high reset: sport mode, reapply pending, sums cleared.
// A stalled result holds the result register; the input register takes at
// most one more beat, then sample.ready drops until result.ready returns.
`default_nettype none

module sensor_window_mode_selector #(
  parameter int WINDOW = swms_pkg::WINDOW_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  swms_stream_if.sink   sample,
  swms_stream_if.source result,
  swms_cfg_if.sink      cfg
);

  logic              hold_valid;
  swms_pkg::sample_t hold_data;
  logic              out_valid;
  swms_pkg::result_t out_data;

  swms_pkg::cfg_t    cfg_regs;
  swms_pkg::result_t res;
  logic              advance;

  assign advance      = hold_valid && (!out_valid || result.ready);
  assign sample.ready = !hold_valid || advance;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  swms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.wdata),
    .cfg      (cfg_regs)
  );

  swms_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .smp  (hold_data),
    .cfg  (cfg_regs),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (sample.ready) hold_valid <= sample.valid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) hold_data <= sample.data;
    if (advance) out_data <= res;
  end

endmodule

`default_nettype wire

[tb/sensor_window_mode_selector_tb.sv]
module sensor_window_mode_selector_tb;

  localparam int WIN         = swms_pkg::WINDOW_DEF;
  localparam int IDLE_LIMIT  = 500;
  localparam int PHASES      = 12;
  localparam int PHASE_TICKS = 120;

  // Codes outside the documented range; the block must treat them as described.
  localparam logic [1:0] BTN_UNUSED  = 2'd3;
  localparam logic [1:0] KILL_UNUSED = 2'd3;
  localparam logic [1:0] EXT_INVALID = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swms_stream_if #(.payload_t(swms_pkg::sample_t)) sample_ch ();
  swms_stream_if #(.payload_t(swms_pkg::result_t)) result_ch ();
  swms_cfg_if cfg_ch ();

  sensor_window_mode_selector dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the block's registers and window state
  logic [1:0] btn_kind_q, kill_src_q;
  logic       crash_en_q, stand_en_q;
  logic [3:0] tick_cnt, btn_sum, crash_sum, stand_sum;
  logic [1:0] mode_q, ext_mode_q;
  logic       kill_q, reapply_q;

  swms_pkg::sample_t tick_queue[$];
  swms_pkg::result_t expected_status[$];

  int  ticks_sent = 0;
  int  ones_left[3];
  int  mismatches = 0;
  int  results_seen = 0;
  int  quiet_cycles;
  int  src_gap;
  int  snk_gap;
  bit  calm = 1'b0;

  function automatic logic pin_high(logic [3:0] sum);
    return int'(sum) * 5 > 4 * WIN;
  endfunction

  function automatic logic pin_low(logic [3:0] sum);
    return int'(sum) * 5 < WIN;
  endfunction

  function automatic void clear_window_model();
    btn_kind_q = swms_pkg::BTN_PHYSICAL;
    kill_src_q = swms_pkg::KILL_NONE;
    crash_en_q = 1'b0;
    stand_en_q = 1'b0;
    tick_cnt   = '0;
    btn_sum    = '0;
    crash_sum  = '0;
    stand_sum  = '0;
    mode_q     = swms_pkg::MODE_SPORT;
    ext_mode_q = swms_pkg::MODE_SPORT;
    kill_q     = 1'b0;
    reapply_q  = 1'b1;
  endfunction

  // Advance the shadow state by one tick and return the status it produces.
  function automatic swms_pkg::result_t window_step(swms_pkg::sample_t s);
    swms_pkg::result_t r;
    logic [1:0]        nxt;
    logic              b_low, b_high;
    r = '0;
    if (s.set_external && s.external_value <= swms_pkg::MODE_ROAD)
      ext_mode_q = s.external_value;
    if (s.reapply_request)
      reapply_q = 1'b1;
    if (int'(tick_cnt) < WIN) begin
      btn_sum   = btn_sum + 4'(s.button_pin);
      crash_sum = crash_sum + 4'(s.crash_pin);
      stand_sum = stand_sum + 4'(s.stand_pin);
      tick_cnt  = tick_cnt + 4'd1;
    end
    if (int'(tick_cnt) >= WIN) begin
      b_low  = pin_low(btn_sum);
      b_high = pin_high(btn_sum);
      r.window_done = 1'b1;
      if (btn_kind_q == swms_pkg::BTN_PHYSICAL && b_low &&
          (kill_src_q == swms_pkg::KILL_BUTTON ||
           kill_src_q == swms_pkg::KILL_BUTTON_BRAKE))
        kill_q = 1'b1;
      if (btn_kind_q == swms_pkg::BTN_PHYSICAL) begin
        nxt = mode_q;
        if (b_high)
          nxt = swms_pkg::MODE_SPORT;
        if (b_low)
          nxt = swms_pkg::MODE_ECO;
        if (ext_mode_q == swms_pkg::MODE_ROAD)
          nxt = swms_pkg::MODE_ROAD;
      end else if (btn_kind_q == swms_pkg::BTN_EXTERNAL) begin
        nxt = ext_mode_q;
      end else begin
        nxt = swms_pkg::MODE_SPORT;
      end
      if (mode_q != nxt || (mode_q != swms_pkg::MODE_SPORT && reapply_q)) begin
        mode_q = nxt;
        if (ext_mode_q != swms_pkg::MODE_ROAD)
          ext_mode_q = nxt;
        r.apply_mode = !kill_q;
      end
      reapply_q    = 1'b0;
      r.warn_crash = crash_en_q && pin_high(crash_sum);
      r.warn_stand = stand_en_q && pin_high(stand_sum);
      r.warn_kill  = kill_q;
      r.warning_any = r.warn_crash | r.warn_stand | r.warn_kill;
      tick_cnt  = '0;
      btn_sum   = '0;
      crash_sum = '0;
      stand_sum = '0;
    end
    r.drive_mode = mode_q;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("ERROR status beat %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Source side: one tick per beat, random gap after each beat unless calm
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.data  <= '0;
      src_gap = 0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (src_gap > 0) begin
        sample_ch.valid <= 1'b0;
        src_gap--;
      end else if (tick_queue.size() > 0) begin
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= tick_queue.pop_front();
        src_gap = calm ? 0 : $urandom_range(17, 0);
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Sink side: stall a random number of cycles after each beat unless calm
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        snk_gap = calm ? 0 : $urandom_range(17, 0);
      if (snk_gap > 0) begin
        result_ch.ready <= 1'b0;
        snk_gap--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    swms_pkg::result_t want;
    if (rst) begin
      clear_window_model();
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_ch.valid && cfg_ch.ready) begin
        quiet_cycles = 0;
        case (cfg_ch.index)
          swms_pkg::REG_BUTTON_KIND:  btn_kind_q = cfg_ch.wdata;
          swms_pkg::REG_KILL_SOURCE:  kill_src_q = cfg_ch.wdata;
          swms_pkg::REG_CRASH_ENABLE: crash_en_q = cfg_ch.wdata[0];
          swms_pkg::REG_STAND_ENABLE: stand_en_q = cfg_ch.wdata[0];
          default: ;
        endcase
      end
      if (result_ch.valid && result_ch.ready) begin
        quiet_cycles = 0;
        results_seen++;
        if (expected_status.size() == 0) begin
          report_mismatch("status beat with no tick outstanding");
        end else begin
          want = expected_status.pop_front();
          check_field("window_done", int'(result_ch.data.window_done),
                      int'(want.window_done));
          check_field("drive_mode", int'(result_ch.data.drive_mode),
                      int'(want.drive_mode));
          check_field("apply_mode", int'(result_ch.data.apply_mode),
                      int'(want.apply_mode));
          check_field("warning_any", int'(result_ch.data.warning_any),
                      int'(want.warning_any));
          check_field("warn_crash", int'(result_ch.data.warn_crash),
                      int'(want.warn_crash));
          check_field("warn_stand", int'(result_ch.data.warn_stand),
                      int'(want.warn_stand));
          check_field("warn_kill", int'(result_ch.data.warn_kill),
                      int'(want.warn_kill));
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        quiet_cycles = 0;
        expected_status.push_back(window_step(sample_ch.data));
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_tick(swms_pkg::sample_t s);
    tick_queue.push_back(s);
    ticks_sent++;
  endtask

  // Pin count for one window, weighted toward the decision thresholds
  function automatic int pick_ones();
    case ($urandom_range(5, 0))
      0:       return $urandom_range(2, 0);
      1:       return $urandom_range(WIN, 13);
      2:       return $urandom_range(1, 0) ? 3 : 12;
      default: return $urandom_range(WIN, 0);
    endcase
  endfunction

  // Each window gets an exact count of high ticks per pin, spread at random.
  task automatic gen_ticks(int n);
    swms_pkg::sample_t s;
    logic [2:0]        pins;
    int                slots;
    for (int i = 0; i < n; i++) begin
      if (ticks_sent % WIN == 0)
        for (int p = 0; p < 3; p++)
          ones_left[p] = pick_ones();
      slots = WIN - ticks_sent % WIN;
      for (int p = 0; p < 3; p++) begin
        pins[p] = ($urandom_range(slots, 1) <= ones_left[p]);
        if (pins[p])
          ones_left[p]--;
      end
      s.button_pin      = pins[0];
      s.crash_pin       = pins[1];
      s.stand_pin       = pins[2];
      s.set_external    = ($urandom_range(7, 0) == 0);
      s.external_value  = 2'($urandom_range(3, 0));
      s.reapply_request = ($urandom_range(9, 0) == 0);
      push_tick(s);
    end
  endtask

  task automatic write_reg(logic [swms_pkg::CFG_IDX_W-1:0] idx,
                           logic [swms_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold until every tick has been sent and every status beat checked.
  task automatic wait_drained();
    while (tick_queue.size() != 0 || expected_status.size() != 0 || sample_ch.valid)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    swms_pkg::sample_t s;
    logic [1:0]        kind, kill, crash_en, stand_en;

    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // All pins high; invalid external write ignored; reapply while in sport
    for (int i = 0; i < WIN; i++) begin
      s = '0;
      s.button_pin      = 1'b1;
      s.crash_pin       = 1'b1;
      s.stand_pin       = 1'b1;
      s.set_external    = (i == 0);
      s.external_value  = (i == 0) ? EXT_INVALID : swms_pkg::MODE_ECO;
      s.reapply_request = (i == 4);
      push_tick(s);
    end
    // All pins low; road legal written on the closing tick overrides the button
    for (int i = 0; i < WIN; i++) begin
      s = '0;
      s.reapply_request = (i == 0);
      s.set_external    = (i == WIN - 1);
      s.external_value  = (i == WIN - 1) ? swms_pkg::MODE_ROAD : swms_pkg::MODE_ECO;
      push_tick(s);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      crash_en = 2'($urandom_range(3, 0));
      stand_en = 2'($urandom_range(3, 0));
      case (ph)
        0: begin
          kind = BTN_UNUSED; kill = KILL_UNUSED; crash_en = 2'b11; stand_en = 2'b11;
        end
        1: begin
          kind = swms_pkg::BTN_PHYSICAL; kill = swms_pkg::KILL_NONE;
          crash_en = 2'b00; stand_en = 2'b00;
        end
        2: begin
          kind = swms_pkg::BTN_EXTERNAL; kill = swms_pkg::KILL_BUTTON;
        end
        3: begin
          kind = swms_pkg::BTN_FIXED; kill = swms_pkg::KILL_BUTTON_BRAKE;
        end
        PHASES - 2: begin
          kind = swms_pkg::BTN_PHYSICAL;
          kill = $urandom_range(1, 0) ? swms_pkg::KILL_BUTTON : swms_pkg::KILL_BUTTON_BRAKE;
        end
        PHASES - 1: begin
          kind = swms_pkg::BTN_EXTERNAL; kill = 2'($urandom_range(3, 0));
        end
        default: begin
          kind = 2'($urandom_range(3, 0));
          kill = 2'($urandom_range(3, 0));
          // keep the kill switch clear until the closing phases; it never unlatches
          if (kind == swms_pkg::BTN_PHYSICAL &&
              (kill == swms_pkg::KILL_BUTTON || kill == swms_pkg::KILL_BUTTON_BRAKE))
            kill = $urandom_range(1, 0) ? swms_pkg::KILL_NONE : KILL_UNUSED;
        end
      endcase
      write_reg(swms_pkg::REG_BUTTON_KIND, kind);
      write_reg(swms_pkg::REG_KILL_SOURCE, kill);
      write_reg(swms_pkg::REG_CRASH_ENABLE, crash_en);
      write_reg(swms_pkg::REG_STAND_ENABLE, stand_en);
      calm = (ph % 3 == 1);
      gen_ticks(PHASE_TICKS);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
